[sv/rsc_pkg.sv]
// Shared widths, codes and defaults for the RPN stack calculator.
// No dependencies; compiled first.
package rsc_pkg;

  localparam int DATA_W          = 32;
  localparam int KIND_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 5;
  localparam int STACK_DEPTH_DEF = 16;
  // Q16.16 divide: 48 quotient bits, one per cycle
  localparam int DIV_STEPS       = 48;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

[sv/rsc_if.sv]
// Valid/ready channel interfaces for operation words in and result words out.
// Depends on rsc_pkg.
interface rsc_in_if;
  import rsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, kind, operand_value, input ready);
  modport sink   (input valid, kind, operand_value, output ready);
endinterface

interface rsc_out_if;
  import rsc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_W-1:0]       stack_count;

  modport source (output valid, top_value, status, stack_count, input ready);
  modport sink   (input valid, top_value, status, stack_count, output ready);
endinterface

[sv/rpn_stack_calculator.sv]
// RPN calculator over a bounded Q16.16 operand stack held in a synchronous RAM.
// Depends on rsc_pkg and the channel interfaces in rsc_if.sv.
//
//   channel  dir  word
//   item     in   kind, operand_value
//   result   out  top_value, status, stack_count
//
// One item at a time. Push, no-op and underflow go straight to output; add/sub and
// divide by zero read then write back; multiply registers the product before
// shift and saturate; the restoring divider retires one quotient bit a cycle.
// Top of stack is cached in a register; the entry below is one RAM read.
// Reset empties the stack at once; RAM contents are don't-care until pushed.
// A result waiting on a stalled sink holds the next item in its final state.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rsc_in_if.sink    item,
  rsc_out_if.source result
);
  import rsc_pkg::*;

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = (SPW > COUNT_W) ? SPW : COUNT_W;
  localparam int QW  = 2 * DATA_W - 16;
  localparam int CNTW = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_MUL, S_DIV, S_DFIX, S_WB, S_FIN
  } state_t;

  state_t                   state;
  logic [SPW-1:0]           sp;
  logic signed [DATA_W-1:0] top;
  logic signed [DATA_W-1:0] res;
  logic [STATUS_W-1:0]      st;
  logic [KIND_W-1:0]        kind_r;
  logic signed [2*DATA_W-1:0] prod;
  logic [QW-1:0]            dvd;
  logic [DATA_W-1:0]        rem;
  logic [DATA_W-1:0]        dvs;
  logic                     q_neg;
  logic [CNTW-1:0]          cnt;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_top;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_W-1:0]       out_count;

  // stack RAM
  logic [DATA_W-1:0]        stack_mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;

  logic                     accept;
  logic                     full;
  logic [CW-1:0]            sp_ext;

  logic signed [DATA_W:0]   addsub;
  logic signed [2*DATA_W-1:0] prod_sh;
  logic [DATA_W-1:0]        n_abs;
  logic [DATA_W-1:0]        t_abs;
  logic [DATA_W:0]          rem_sh;
  logic [DATA_W:0]          rem_diff;
  logic                     rem_ge;
  logic [DATA_W-1:0]        q_lo_neg;

  assign accept    = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign full      = (sp == SPW'(STACK_DEPTH));
  assign rd_addr   = AW'(sp - SPW'(2));
  assign sp_ext    = CW'(sp);

  assign result.valid       = out_valid;
  assign result.top_value   = out_top;
  assign result.status      = out_status;
  assign result.stack_count = out_count;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = res;
    if (accept && item.kind == KIND_PUSH && !full) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(sp);
      mem_wdata = item.operand_value;
    end else if (state == S_WB) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= stack_mem[rd_addr];
  end

  // datapath terms; n comes from rd_data in S_READ, t is the cached top
  always_comb begin
    if (kind_r == KIND_SUB) begin
      addsub = {rd_data[DATA_W-1], rd_data} - {top[DATA_W-1], top};
    end else begin
      addsub = {rd_data[DATA_W-1], rd_data} + {top[DATA_W-1], top};
    end
    prod_sh  = prod >>> 16;
    n_abs    = rd_data[DATA_W-1] ? (~rd_data + 1'b1) : rd_data;
    t_abs    = top[DATA_W-1] ? (~top + 1'b1) : top;
    rem_sh   = {rem, dvd[QW-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    rem_ge   = (rem_sh >= {1'b0, dvs});
    q_lo_neg = ~dvd[DATA_W-1:0] + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_FIN refills the output register itself
      if (out_valid && result.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r <= item.kind;
            st     <= ST_OK;
            state  <= S_FIN;
            case (item.kind)
              KIND_PUSH: begin
                if (full) begin
                  st <= ST_OVER;
                end else begin
                  top <= item.operand_value;
                  sp  <= sp + 1'b1;
                end
              end
              KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                if (sp < SPW'(2)) begin
                  st <= ST_UNDER;
                end else begin
                  state <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          case (kind_r)
            KIND_ADD, KIND_SUB: begin
              if (addsub[DATA_W] != addsub[DATA_W-1]) begin
                res <= addsub[DATA_W] ? Q_MIN : Q_MAX;
              end else begin
                res <= addsub[DATA_W-1:0];
              end
              state <= S_WB;
            end
            KIND_MUL: begin
              prod  <= rd_data * top;
              state <= S_MUL;
            end
            default: begin
              if (top == '0) begin
                st    <= ST_DIVZERO;
                res   <= rd_data[DATA_W-1] ? Q_MIN : Q_MAX;
                state <= S_WB;
              end else begin
                dvd   <= {n_abs, 16'b0};
                rem   <= '0;
                dvs   <= t_abs;
                q_neg <= rd_data[DATA_W-1] ^ top[DATA_W-1];
                cnt   <= CNTW'(DIV_STEPS - 1);
                state <= S_DIV;
              end
            end
          endcase
        end
        S_MUL: begin
          // floor shift, then clamp unless bits 63..31 agree
          if (prod_sh[2*DATA_W-1:DATA_W-1] == '0 || prod_sh[2*DATA_W-1:DATA_W-1] == '1) begin
            res <= prod_sh[DATA_W-1:0];
          end else begin
            res <= prod_sh[2*DATA_W-1] ? Q_MIN : Q_MAX;
          end
          state <= S_WB;
        end
        S_DIV: begin
          // restoring step; quotient bits shift into dvd as dividend bits leave
          rem <= rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
          dvd <= {dvd[QW-2:0], rem_ge};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_DFIX;
          end
        end
        S_DFIX: begin
          if (q_neg) begin
            if (dvd[QW-1:DATA_W] != '0 ||
                (dvd[DATA_W-1] && dvd[DATA_W-2:0] != '0)) begin
              res <= Q_MIN;
            end else begin
              res <= q_lo_neg;
            end
          end else begin
            if (dvd[QW-1:DATA_W-1] != '0) begin
              res <= Q_MAX;
            end else begin
              res <= dvd[DATA_W-1:0];
            end
          end
          state <= S_WB;
        end
        S_WB: begin
          // result overwrites the lower operand; two pops and one push
          top   <= res;
          sp    <= sp - 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_top    <= (sp == '0) ? '0 : top;
            out_status <= st;
            out_count  <= sp_ext[COUNT_W-1:0];
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("second word taken while busy");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && st == ST_OVER) |-> full)
    else $error("overflow reported on a stack that is not full");

  a_under_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && st == ST_UNDER) |-> (sp < SPW'(2)))
    else $error("underflow reported with two or more entries");

endmodule
